### hdl/sap_pkg.sv
// Package: shared types and constants for the shelf atlas packer.
`timescale 1ns / 1ps
package sap_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_SIDE_DEF = 4096;
    localparam int CW = 17;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SIDE   = 2'd2;

    typedef struct packed {
        logic        start_new;
        logic [15:0] item_tag;
        logic [12:0] item_width;
        logic [12:0] item_height;
        logic [10:0] pad_x;
        logic [10:0] pad_y;
    } in_word_t;

    typedef struct packed {
        logic [15:0] out_tag;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_w;
        logic [12:0] out_h;
        logic [12:0] atlas_side;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] w;
        logic [CW-1:0] h;
        logic [CW-1:0] last_h;
    } row_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic place_row;
        logic shift_step;
        logic write_sub;
        logic new_shelf;
        logic grow;
        logic finish;
        logic [1:0] fin_status;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic hit;
        logic split;
        logic full;
        logic shift_done;
        logic shelf_fits;
        logic grow_ok;
    } sts_t;

endpackage

### hdl/sap_ctrl.sv
// Controller: sequences scan, insert shift, shelf open and growth.
`timescale 1ns / 1ps
module sap_ctrl
    import sap_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_TEST  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       busy;

    assign busy      = (state_reg != S_IDLE) && (state_reg != S_OUT);
    assign in_stall  = busy || (state_reg == S_OUT && out_stall);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_OUT:
            begin
                if (state_reg == S_OUT && out_stall)
                    state_next = S_OUT;
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_START;
                end
                else
                    state_next = S_IDLE;
            end
            S_START:
            begin
                cmd.scan_start = 1'b1;
                state_next = S_READ;
            end
            S_READ:
                state_next = S_TEST;
            S_TEST:
            begin
                if (!sts.scan_end)
                begin
                    if (sts.hit)
                    begin
                        if (sts.split && sts.full)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fin_status = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.place_row = 1'b1;
                            state_next = sts.split ? S_SHIFT : S_OUT;
                            if (!sts.split)
                            begin
                                cmd.finish = 1'b1;
                                cmd.fin_status = ST_PLACED;
                            end
                        end
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                        state_next = S_READ;
                    end
                end
                else if (sts.shelf_fits)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                    if (sts.full)
                        cmd.fin_status = ST_FULL;
                    else
                    begin
                        cmd.new_shelf = 1'b1;
                        cmd.fin_status = ST_PLACED;
                    end
                end
                else if (sts.grow_ok)
                begin
                    cmd.grow = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_SIDE;
                    state_next = S_OUT;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    cmd.write_sub = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_PLACED;
                    state_next = S_OUT;
                end
                else
                    cmd.shift_step = 1'b1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hdl/sap_dp.sv
// Datapath: row memory, atlas registers and result formatting.
`timescale 1ns / 1ps
module sap_dp
    import sap_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [3:0] side_log2,
    input  in_word_t  in_word,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_word_t out_word
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int NW = $clog2(MAX_ROWS + 1);
    localparam int SW = $clog2(MAX_SIDE) + 2;

    row_t row_mem [MAX_ROWS];
    row_t rd_reg;
    row_t sub_reg;

    in_word_t     item_reg;
    logic [SW-1:0] side_reg, side_tmp_reg;
    logic [SW-1:0] used_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] idx_reg;
    logic [NW-1:0] sh_reg;
    logic [CW-1:0] ox_reg, oy_reg;
    out_word_t     res_reg;

    logic [CW-1:0] iw, ih, side_c, used_c, rem_w;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] init_side;
    logic          do_wr;
    logic [AW-1:0] wr_addr;
    row_t          wr_data;
    logic [CW-1:0] fx, fy;
    logic [CW:0]   fw, fh;

    assign iw     = CW'(item_reg.item_width);
    assign ih     = CW'(item_reg.item_height);
    assign side_c = CW'(side_tmp_reg);
    assign used_c = CW'(used_reg);
    assign rem_w  = side_c - rd_reg.w - rd_reg.x;

    always_comb
    begin
        if (side_log2 >= 4'($clog2(MAX_SIDE)))
            init_side = SW'(MAX_SIDE);
        else
            init_side = SW'(1) << side_log2;
    end

    assign sts.scan_end   = (idx_reg >= cnt_reg);
    assign sts.hit        = (rd_reg.h >= ih) && !rem_w[CW-1] && (rem_w >= iw);
    assign sts.split      = (rd_reg.last_h > ih);
    assign sts.full       = (cnt_reg >= NW'(MAX_ROWS));
    assign sts.shift_done = (sh_reg <= idx_reg + NW'(1));
    assign sts.shelf_fits = ((side_c - used_c) >= ih) && (iw <= side_c);
    assign sts.grow_ok    = !((side_tmp_reg << 1) > SW'(MAX_SIDE));

    // shift reads run one row ahead of the write: the last row first, then sh - 2
    always_comb
    begin
        rd_addr = idx_reg[AW-1:0];
        if (cmd.scan_step)
            rd_addr = AW'(idx_reg + NW'(1));
        else if (cmd.scan_start)
            rd_addr = '0;
        else if (cmd.place_row)
            rd_addr = AW'(cnt_reg - NW'(1));
        else if (cmd.shift_step)
            rd_addr = AW'(sh_reg - NW'(2));
    end

    always_comb
    begin
        do_wr = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_reg;
        if (cmd.place_row)
        begin
            do_wr = 1'b1;
            wr_data.w = rd_reg.w + iw;
            wr_data.last_h = ih;
            if (sts.split)
                wr_data.h = ih;
        end
        else if (cmd.shift_step)
        begin
            do_wr = 1'b1;
            wr_addr = sh_reg[AW-1:0];
        end
        else if (cmd.write_sub)
        begin
            do_wr = 1'b1;
            wr_addr = AW'(idx_reg + NW'(1));
            wr_data = sub_reg;
        end
        else if (cmd.new_shelf)
        begin
            do_wr = 1'b1;
            wr_addr = cnt_reg[AW-1:0];
            wr_data.x = '0;
            wr_data.y = used_c;
            wr_data.w = iw;
            wr_data.h = ih;
            wr_data.last_h = ih;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            row_mem[wr_addr] <= wr_data;
        rd_reg <= row_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_word;
        if (cmd.place_row)
        begin
            ox_reg <= rd_reg.x + rd_reg.w;
            oy_reg <= rd_reg.y;
            sub_reg.x <= rd_reg.x + rd_reg.w;
            sub_reg.y <= rd_reg.y + ih;
            sub_reg.w <= '0;
            sub_reg.h <= rd_reg.h - ih;
            sub_reg.last_h <= rd_reg.h - ih;
        end
        else if (cmd.new_shelf)
        begin
            ox_reg <= '0;
            oy_reg <= used_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SW'(64);
            side_tmp_reg <= SW'(64);
            used_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            sh_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (in_word.start_new)
                begin
                    side_reg <= init_side;
                    side_tmp_reg <= init_side;
                    used_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                    side_tmp_reg <= side_reg;
            end
            if (cmd.grow)
                side_tmp_reg <= side_tmp_reg << 1;
            if (cmd.scan_start)
                idx_reg <= '0;
            else if (cmd.scan_step)
                idx_reg <= idx_reg + NW'(1);
            if (cmd.place_row)
                sh_reg <= cnt_reg;
            else if (cmd.shift_step)
                sh_reg <= sh_reg - NW'(1);
            if (cmd.write_sub || cmd.new_shelf)
                cnt_reg <= cnt_reg + NW'(1);
            if (cmd.new_shelf)
                used_reg <= used_reg + SW'(ih);
            if (cmd.finish && cmd.fin_status == ST_PLACED)
                side_reg <= side_tmp_reg;
        end
    end

    assign fx = (cmd.new_shelf ? CW'(0) : (cmd.place_row ? rd_reg.x + rd_reg.w : ox_reg))
                + CW'(item_reg.pad_x);
    assign fy = (cmd.new_shelf ? used_c : (cmd.place_row ? rd_reg.y : oy_reg))
                + CW'(item_reg.pad_y);
    assign fw = {1'b0, iw} - {CW'(item_reg.pad_x), 1'b0};
    assign fh = {1'b0, ih} - {CW'(item_reg.pad_y), 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_reg.out_tag <= item_reg.item_tag;
            res_reg.status <= cmd.fin_status;
            if (cmd.fin_status == ST_PLACED)
            begin
                res_reg.out_x <= (fx > CW'(4095)) ? 12'd4095 : fx[11:0];
                res_reg.out_y <= (fy > CW'(4095)) ? 12'd4095 : fy[11:0];
                res_reg.out_w <= fw[CW] ? 13'd0 : fw[12:0];
                res_reg.out_h <= fh[CW] ? 13'd0 : fh[12:0];
                res_reg.atlas_side <= side_tmp_reg[12:0];
            end
            else
            begin
                res_reg.out_x <= '0;
                res_reg.out_y <= '0;
                res_reg.out_w <= '0;
                res_reg.out_h <= '0;
                res_reg.atlas_side <= side_reg[12:0];
            end
        end
    end

    assign out_word = res_reg;

endmodule

### hdl/shelf_atlas_packer.sv
// Top level of the shelf atlas packer.
// Each word is loaded and the rows are scanned in turn; each growth of the side scans the rows again.
// A split also shifts the rows below the hit down by one to make room for the sub-row.
// One word at a time: a new word is stalled until the result for the last one has been taken.
// Reset: side 64, no rows, initial_side_log2 = 6; row memory contents are not cleared.
`timescale 1ns / 1ps
module shelf_atlas_packer
    import sap_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_SIDE = MAX_SIDE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [3:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic [3:0] side_log2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side_log2_reg <= 4'd6;
        else if (cfg_valid && cfg_ready)
            side_log2_reg <= cfg_data;
    end

    sap_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .sts(sts)
    );

    sap_dp #(.MAX_ROWS(MAX_ROWS), .MAX_SIDE(MAX_SIDE)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .side_log2(side_log2_reg), .in_word(in_data),
        .cmd(cmd), .sts(sts), .out_word(out_data)
    );

endmodule

### hdl/sap_checker.sv
// Port checker for the shelf atlas packer, bound to the top level.
`timescale 1ns / 1ps
module sap_checker
    import sap_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("bad status code");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_PLACED |-> out_data.out_w == 13'd0
        && out_data.out_x == 12'd0)
        else $error("rejected word carries a placement");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result shown right after acceptance");

endmodule

bind shelf_atlas_packer sap_checker u_sap_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
);
